// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGES      = 1024;
  localparam int TIME_BITS  = 32;

  // Fixed field widths of the channels.
  localparam int PAGE_W   = 10;
  localparam int FRAME_W  = 4;
  localparam int CFG_W    = 5;
  localparam int FAULT_W  = 32;

  localparam int PAGE_BITS  = $clog2(PAGES);
  localparam int FRAME_BITS = $clog2(MAX_FRAMES);
  localparam int FCNT_BITS  = $clog2(MAX_FRAMES + 1);

  // Victim search: frames are folded in groups, and only the first fold is registered.
  localparam int GRP  = 4;
  localparam int NGRP = (MAX_FRAMES + GRP - 1) / GRP;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // One entry of the page map: resident flag and frame number.
  typedef struct packed {
    logic                  resident;
    logic [FRAME_BITS-1:0] slot;
  } map_entry_t;

  localparam int MAP_W = $bits(map_entry_t);

  // Candidate of the least-recently-used search.
  typedef struct packed {
    logic                  v;
    logic [FRAME_BITS-1:0] idx;
    logic [TIME_BITS-1:0]  t;
  } lru_node_t;

  // Keeps a (the lower index) unless a is invalid, or b is valid and strictly older.
  function automatic lru_node_t min_pick(lru_node_t a, lru_node_t b);
    lru_node_t r;
    if (!a.v) begin
      r = b;
    end else if (b.v && (b.t < a.t)) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lrupr_if.sv =====
interface lrupr_in_if;
  logic                           valid;
  logic                           ready;
  logic [lrupr_pkg::PAGE_W-1:0]   page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lrupr_pkg::FRAME_W-1:0]  frame_index;
  logic                           evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]   evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]  fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

interface lrupr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lrupr_pkg::CFG_W-1:0]    frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

// ===== rtl/lrupr_ram.sv =====
module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// Least-recently-used page replacement over up to 16 frames. Each input item
// is one page reference; each yields exactly one result item reporting hit or
// fault, the frame now holding the page, the evicted page (if any) and the
// saturating fault count. The page-to-frame map lives in a 1024-entry
// synchronous RAM; the per-frame page and last-use time live in registers.
// After reset the block clears the page map one entry per cycle, and it
// accepts no item until that pass is done (configuration writes are taken
// throughout). An item then passes through accept and map read, map data
// plus first fold of the oldest-frame search, and decision and write-back;
// an eviction adds a further step, a second map write to mark the evicted
// page not resident, which the single map write port makes necessary. A
// new item is accepted while the previous result still waits on the output
// register. frames_in_use may only be written while the block is idle; 0
// acts as 1 and values above 16 act as 16.
module lru_page_replacement (
  input  logic          clk,
  input  logic          rst_n,
  lrupr_cfg_if.sink     cfg_ch,
  lrupr_in_if.sink      in_ch,
  lrupr_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAP   = 4'b0010,
    S_DEC   = 4'b0100,
    S_EVICT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [lrupr_pkg::CFG_W-1:0] frames_in_use_r;
  logic [lrupr_pkg::FCNT_BITS-1:0] n_eff;

  // Map clearing pass after reset.
  logic [lrupr_pkg::PAGE_BITS:0] clr_cnt_r;
  logic clr_done;

  // Frame state. Never read before written, so no reset.
  logic [lrupr_pkg::PAGE_BITS-1:0] frame_page_r [lrupr_pkg::MAX_FRAMES];
  logic [lrupr_pkg::TIME_BITS-1:0] last_use_r [lrupr_pkg::MAX_FRAMES];

  logic [lrupr_pkg::FCNT_BITS-1:0] fill_r;
  logic [lrupr_pkg::TIME_BITS-1:0] ref_clock_r, ref_clock_nxt;
  logic [lrupr_pkg::FAULT_W-1:0]   fault_r, fault_nxt;
  logic [lrupr_pkg::PAGE_BITS-1:0] page_r;

  // Oldest-frame search, first fold registered per group.
  lrupr_pkg::lru_node_t grp_r [lrupr_pkg::NGRP];
  lrupr_pkg::lru_node_t grp_nxt [lrupr_pkg::NGRP];
  lrupr_pkg::lru_node_t victim;

  // Page map RAM.
  logic                              map_we, map_re;
  logic [lrupr_pkg::PAGE_BITS-1:0]   map_waddr;
  lrupr_pkg::map_entry_t             map_wdata, map_rd;

  // Output register.
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [lrupr_pkg::FRAME_W-1:0]     out_frame_r;
  logic                              out_ev_valid_r;
  logic [lrupr_pkg::PAGE_W-1:0]      out_ev_page_r;

  // Decision signals.
  logic                              in_acc, dec_go, out_take, is_hit, do_fill;
  logic [lrupr_pkg::FRAME_BITS-1:0]  frame_sel;
  logic [lrupr_pkg::PAGE_BITS-1:0]   ev_page;

  assign clr_done = clr_cnt_r[lrupr_pkg::PAGE_BITS];

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE) && clr_done;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_take     = out_valid_r && out_ch.ready;
  assign dec_go       = (state_r == S_DEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (frames_in_use_r == '0) begin
      n_eff = lrupr_pkg::FCNT_BITS'(1);
    end else if (frames_in_use_r > lrupr_pkg::CFG_W'(lrupr_pkg::MAX_FRAMES)) begin
      n_eff = lrupr_pkg::FCNT_BITS'(lrupr_pkg::MAX_FRAMES);
    end else begin
      n_eff = lrupr_pkg::FCNT_BITS'(frames_in_use_r);
    end
  end

  // First fold: each group of frames reduced to its oldest active member.
  always_comb begin
    for (int g = 0; g < lrupr_pkg::NGRP; g++) begin
      lrupr_pkg::lru_node_t acc;
      acc = '0;
      for (int k = 0; k < lrupr_pkg::GRP; k++) begin
        lrupr_pkg::lru_node_t e;
        e = '0;
        if (g * lrupr_pkg::GRP + k < lrupr_pkg::MAX_FRAMES) begin
          e.v   = (lrupr_pkg::FCNT_BITS'(g * lrupr_pkg::GRP + k) < n_eff);
          e.idx = lrupr_pkg::FRAME_BITS'(g * lrupr_pkg::GRP + k);
          e.t   = last_use_r[g * lrupr_pkg::GRP + k];
        end
        acc = lrupr_pkg::min_pick(acc, e);
      end
      grp_nxt[g] = acc;
    end
  end

  // Second fold over the registered group winners; lower groups win ties.
  always_comb begin
    victim = '0;
    for (int g = 0; g < lrupr_pkg::NGRP; g++) begin
      victim = lrupr_pkg::min_pick(victim, grp_r[g]);
    end
  end

  assign is_hit  = map_rd.resident;
  assign do_fill = fill_r < n_eff;
  assign ev_page = frame_page_r[victim.idx];

  always_comb begin
    if (is_hit) begin
      frame_sel = map_rd.slot;
    end else if (do_fill) begin
      frame_sel = fill_r[lrupr_pkg::FRAME_BITS-1:0];
    end else begin
      frame_sel = victim.idx;
    end
  end

  assign ref_clock_nxt = (ref_clock_r == '1) ? ref_clock_r : ref_clock_r + 1'b1;
  assign fault_nxt     = (fault_r == '1) ? fault_r : fault_r + 1'b1;

  // Map write port: clearing pass, new mapping, then evicted page release.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = page_r;
    map_wdata = '0;
    if (!clr_done) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt_r[lrupr_pkg::PAGE_BITS-1:0];
    end else if (dec_go && !is_hit) begin
      map_we         = 1'b1;
      map_wdata.resident = 1'b1;
      map_wdata.slot = frame_sel;
    end else if (state_r == S_EVICT) begin
      map_we    = 1'b1;
      map_waddr = out_ev_page_r;
    end
  end

  assign map_re = in_acc;

  lrupr_ram #(
    .WIDTH (lrupr_pkg::MAP_W),
    .DEPTH (lrupr_pkg::PAGES)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (in_ch.page_number[lrupr_pkg::PAGE_BITS-1:0]),
    .rdata (map_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (dec_go) begin
          state_nxt = (!is_hit && !do_fill) ? S_EVICT : S_IDLE;
        end
      end
      S_EVICT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      frames_in_use_r <= lrupr_pkg::FRAMES_RESET;
      clr_cnt_r       <= '0;
      fill_r          <= '0;
      ref_clock_r     <= '0;
      fault_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        frames_in_use_r <= cfg_ch.frames_in_use;
      end
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (dec_go) begin
        ref_clock_r <= ref_clock_nxt;
        if (!is_hit) begin
          fault_r <= fault_nxt;
          if (do_fill) begin
            fill_r <= fill_r + 1'b1;
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= in_ch.page_number[lrupr_pkg::PAGE_BITS-1:0];
    end
    if (state_r == S_MAP) begin
      grp_r <= grp_nxt;
    end
    if (dec_go) begin
      last_use_r[frame_sel] <= ref_clock_nxt;
      if (!is_hit) begin
        frame_page_r[frame_sel] <= page_r;
      end
      out_hit_r      <= is_hit;
      out_frame_r    <= lrupr_pkg::FRAME_W'(frame_sel);
      out_ev_valid_r <= !is_hit && !do_fill;
      out_ev_page_r  <= (!is_hit && !do_fill) ? lrupr_pkg::PAGE_W'(ev_page) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame_index   = out_frame_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.fault_count   = fault_r;

`ifndef SYNTH
  // No item is taken while the page map is still being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !in_ch.ready)
    else $error("item accepted during map clearing");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_ev_valid_r)
    else $error("hit reported with an eviction");

  // The fill count never passes the number of frames.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lrupr_pkg::FCNT_BITS'(lrupr_pkg::MAX_FRAMES))
    else $error("fill count beyond frame count");

  // An eviction always comes from a decision that found every usable frame filled.
  a_evict_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> ($past(state_r) == S_DEC) && out_ev_valid_r)
    else $error("eviction write without an eviction decision");
`endif

endmodule

// ===== tb/sv/tb_lru_page_replacement.sv =====
module tb_lru_page_replacement;

  // One result item as the block reports it.
  typedef struct packed {
    logic                             hit;
    logic [lrupr_pkg::FRAME_W-1:0]    frame_index;
    logic                             evicted_valid;
    logic [lrupr_pkg::PAGE_W-1:0]     evicted_page;
    logic [lrupr_pkg::FAULT_W-1:0]    fault_count;
  } page_result_t;

  // A row of the directed part is either a page reference or a write of the
  // frame count. For a reference, the expected result is written out in the
  // row when it is obvious; otherwise the predictor supplies it.
  typedef enum logic {ROW_PAGE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [lrupr_pkg::PAGE_W-1:0]    value;
    logic                            typed;
    page_result_t                    want;
  } stim_row_t;

  localparam int NUM_ROWS = 22;

  // The first rows run at the reset frame count of 16. The count is then
  // dropped to 1 while five frames are filled, so the upper frames still hit
  // but only frame 0 is replaced. Zero must act as one, and 31 and 17 must act
  // as 16, with filling resuming where it stopped. The last rows run with
  // three frames, where the victim comes from the last-use times.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_PAGE, 10'd0,    1'b1, '{1'b0, 4'd0, 1'b0, 10'd0, 32'd1}},
    '{ROW_PAGE, 10'd1023, 1'b1, '{1'b0, 4'd1, 1'b0, 10'd0, 32'd2}},
    '{ROW_PAGE, 10'd0,    1'b1, '{1'b1, 4'd0, 1'b0, 10'd0, 32'd2}},
    '{ROW_PAGE, 10'd512,  1'b1, '{1'b0, 4'd2, 1'b0, 10'd0, 32'd3}},
    '{ROW_PAGE, 10'd341,  1'b1, '{1'b0, 4'd3, 1'b0, 10'd0, 32'd4}},
    '{ROW_PAGE, 10'd682,  1'b1, '{1'b0, 4'd4, 1'b0, 10'd0, 32'd5}},
    '{ROW_CFG,  10'd1,    1'b0, '0},
    '{ROW_PAGE, 10'd1023, 1'b1, '{1'b1, 4'd1, 1'b0, 10'd0, 32'd5}},
    '{ROW_PAGE, 10'd7,    1'b1, '{1'b0, 4'd0, 1'b1, 10'd0, 32'd6}},
    '{ROW_PAGE, 10'd0,    1'b1, '{1'b0, 4'd0, 1'b1, 10'd7, 32'd7}},
    '{ROW_PAGE, 10'd512,  1'b1, '{1'b1, 4'd2, 1'b0, 10'd0, 32'd7}},
    '{ROW_CFG,  10'd0,    1'b0, '0},
    '{ROW_PAGE, 10'd5,    1'b1, '{1'b0, 4'd0, 1'b1, 10'd0, 32'd8}},
    '{ROW_CFG,  10'd31,   1'b0, '0},
    '{ROW_PAGE, 10'd100,  1'b1, '{1'b0, 4'd5, 1'b0, 10'd0, 32'd9}},
    '{ROW_CFG,  10'd17,   1'b0, '0},
    '{ROW_PAGE, 10'd101,  1'b1, '{1'b0, 4'd6, 1'b0, 10'd0, 32'd10}},
    '{ROW_CFG,  10'd3,    1'b0, '0},
    '{ROW_PAGE, 10'd200,  1'b0, '0},
    '{ROW_PAGE, 10'd1023, 1'b0, '0},
    '{ROW_PAGE, 10'd101,  1'b0, '0},
    '{ROW_CFG,  10'd16,   1'b0, '0}
  };

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 110;
  localparam int FIXED_PHASES = 6;
  localparam int MAX_REPORTS  = 10;

  // Frame counts of the first random phases: the extremes, the out-of-range
  // codes and one in between. Later phases draw the count at random.
  localparam logic [lrupr_pkg::CFG_W-1:0] PHASE_FRAMES [FIXED_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17
  };

  logic clk;
  logic rst_n;

  lrupr_cfg_if cfg_ch ();
  lrupr_in_if  in_ch ();
  lrupr_out_if out_ch ();

  lru_page_replacement i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the replacement state, updated at every accepted reference.
  logic [lrupr_pkg::PAGE_W-1:0]    frm_page    [lrupr_pkg::MAX_FRAMES];
  logic [lrupr_pkg::TIME_BITS-1:0] frm_used_at [lrupr_pkg::MAX_FRAMES];
  bit                              pg_resident [lrupr_pkg::PAGES];
  logic [lrupr_pkg::FRAME_W-1:0]   pg_frame    [lrupr_pkg::PAGES];
  logic [lrupr_pkg::TIME_BITS-1:0] ref_time;
  logic [lrupr_pkg::FAULT_W-1:0]   faults_seen;
  int                              frames_filled;
  logic [lrupr_pkg::CFG_W-1:0]     frames_cfg;

  page_result_t pending_results [$];
  int           mismatches;

  // Idling controls: no_idle is shared by the sender and the receiver, hold_request drives the receiver only.
  bit no_idle;
  int hold_request;

  always begin
    #4 clk = ~clk;
  end

  // The run ends here if results stop coming.
  initial begin
    #4000000;
    $display("lru_page_replacement test failed");
    $finish;
  end

  function automatic int usable_frames(logic [lrupr_pkg::CFG_W-1:0] cfg);
    if (cfg == 0) begin
      return 1;
    end else if (cfg > lrupr_pkg::MAX_FRAMES) begin
      return lrupr_pkg::MAX_FRAMES;
    end
    return int'(cfg);
  endfunction

  task automatic clear_shadow();
    for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
      frm_page[i]    = '0;
      frm_used_at[i] = '0;
    end
    for (int p = 0; p < lrupr_pkg::PAGES; p++) begin
      pg_resident[p] = 1'b0;
      pg_frame[p]    = '0;
    end
    ref_time      = '0;
    faults_seen   = '0;
    frames_filled = 0;
    frames_cfg    = lrupr_pkg::FRAMES_RESET;
  endtask

  // Applies one reference to the shadow state and returns what the block must
  // report for it.
  function automatic page_result_t resolve_reference(logic [lrupr_pkg::PAGE_W-1:0] page);
    page_result_t res;
    int           n;
    int           victim;
    n   = usable_frames(frames_cfg);
    res = '0;
    if (ref_time != '1) begin
      ref_time = ref_time + 1'b1;
    end
    if (pg_resident[page]) begin
      // A hit only refreshes the frame's time, even for a frame that lies
      // above the current frame count.
      res.hit                  = 1'b1;
      res.frame_index          = pg_frame[page];
      frm_used_at[pg_frame[page]] = ref_time;
    end else begin
      if (frames_filled < n) begin
        victim = frames_filled;
        frames_filled++;
      end else begin
        // Oldest frame among the usable ones; strict compare keeps the lowest
        // index when times are equal.
        victim = 0;
        for (int i = 1; i < n; i++) begin
          if (frm_used_at[i] < frm_used_at[victim]) begin
            victim = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frm_page[victim];
        pg_resident[frm_page[victim]] = 1'b0;
      end
      res.frame_index     = lrupr_pkg::FRAME_W'(victim);
      frm_page[victim]    = page;
      frm_used_at[victim] = ref_time;
      pg_resident[page]   = 1'b1;
      pg_frame[page]      = lrupr_pkg::FRAME_W'(victim);
      if (faults_seen != '1) begin
        faults_seen = faults_seen + 1'b1;
      end
    end
    res.fault_count = faults_seen;
    return res;
  endfunction

  // Offers one page reference. Called and returning at a falling edge; valid
  // is left high so that back-to-back items never lower and raise it in the
  // same step. The shadow state advances at the edge where the item is taken.
  task automatic send_page(logic [lrupr_pkg::PAGE_W-1:0] page, logic typed,
                           page_result_t want);
    page_result_t predicted;
    while (!no_idle && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= page;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = resolve_reference(page);
    if (typed) begin
      predicted = want;
    end
    pending_results = {pending_results, predicted};
    @(negedge clk);
  endtask

  // Stops offering items and waits until every expected result has come and
  // the block has had time to settle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (16) @(negedge clk);
  endtask

  // Writes the frame count; only called while the block is idle.
  task automatic write_frames(logic [lrupr_pkg::CFG_W-1:0] value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.frames_in_use <= value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    frames_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // The receiver drops ready at random, except during a no-idle stretch or a
  // hold-off that the stimulus asks for. During a hold-off the sender keeps
  // offering items, so the block fills up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  // Every result item taken by the receiver is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result item arrived with nothing expected", $time);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_ch.hit !== want.hit) begin
          note_mismatch("hit", 32'(want.hit), 32'(out_ch.hit));
        end
        if (out_ch.frame_index !== want.frame_index) begin
          note_mismatch("frame_index", 32'(want.frame_index), 32'(out_ch.frame_index));
        end
        if (out_ch.evicted_valid !== want.evicted_valid) begin
          note_mismatch("evicted_valid", 32'(want.evicted_valid),
                        32'(out_ch.evicted_valid));
        end
        if (out_ch.evicted_page !== want.evicted_page) begin
          note_mismatch("evicted_page", 32'(want.evicted_page),
                        32'(out_ch.evicted_page));
        end
        if (out_ch.fault_count !== want.fault_count) begin
          note_mismatch("fault_count", want.fault_count, out_ch.fault_count);
        end
      end
    end
  end

  initial begin
    logic [lrupr_pkg::PAGE_W-1:0] pool [2*lrupr_pkg::MAX_FRAMES+4];
    logic [lrupr_pkg::PAGE_W-1:0] page;
    logic [lrupr_pkg::CFG_W-1:0]  setting;
    int                           n;
    int                           pool_size;

    // Every input is known from time zero.
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.page_number    = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.frames_in_use = '0;
    out_ch.ready         = 1'b0;
    no_idle              = 1'b0;
    hold_request         = 0;
    mismatches           = 0;
    clear_shadow();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The block clears its page map after reset, so the first
    // item simply waits on ready until that is done.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        drain_block();
        write_frames(DIRECTED[r].value[lrupr_pkg::CFG_W-1:0]);
      end else begin
        send_page(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // Random part. Each phase sets a frame count and then references pages
    // mostly from a working set of n to 2n+2 pages, n being the usable frames, so
    // hits, fills and evictions all occur; a share of the references go to
    // any page at all. The working set drifts slowly over the phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      setting = (ph < FIXED_PHASES) ? PHASE_FRAMES[ph] :
                lrupr_pkg::CFG_W'($urandom_range(31));
      write_frames(setting);
      n         = usable_frames(setting);
      pool_size = n + $urandom_range(n + 2);
      for (int i = 0; i < pool_size; i++) begin
        pool[i] = lrupr_pkg::PAGE_W'($urandom_range(lrupr_pkg::PAGES - 1));
      end
      // One whole phase runs with neither side idling.
      no_idle = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == 40) begin
          hold_request = 150;
        end
        if (ph == 7 && k == 50) begin
          drain_block();
        end
        if ($urandom_range(99) < 5) begin
          pool[$urandom_range(pool_size - 1)] =
            lrupr_pkg::PAGE_W'($urandom_range(lrupr_pkg::PAGES - 1));
        end
        if ($urandom_range(99) < 12) begin
          page = lrupr_pkg::PAGE_W'($urandom_range(lrupr_pkg::PAGES - 1));
        end else begin
          page = pool[$urandom_range(pool_size - 1)];
        end
        send_page(page, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_block();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_page_replacement test passed");
    end else begin
      $display("lru_page_replacement test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lrupr_pkg.sv
rtl/lrupr_if.sv
rtl/lrupr_ram.sv
rtl/lru_page_replacement.sv
tb/sv/tb_lru_page_replacement.sv
